// ===== hdl/fasthash64_stream_hash_macros.svh =====
// Assertion macros shared by the fasthash64 stream hash RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef FASTHASH64_STREAM_HASH_MACROS_SVH
`define FASTHASH64_STREAM_HASH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FH64_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fasthash64 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FH64_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fasthash64 assertion failed");

`endif

// ===== hdl/fh64_pkg.sv =====
// Shared constants and types for the fasthash64 stream hash.
// Used by the controller, the datapath and the top level; depends on nothing.
package fh64_pkg;

	// Hash constants.
	localparam logic [63:0] HASH_M     = 64'h880355f21e6d1965;
	localparam logic [63:0] MIX_MUL    = 64'h2127598bf4325c37;
	localparam int unsigned MIX_SHIFT1 = 23;
	localparam int unsigned MIX_SHIFT2 = 47;

	// Input tdata layout, lowest field first.
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned SEED_W   = 64;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned WORD_LSB  = 0;
	localparam int unsigned COUNT_LSB = WORD_LSB + WORD_W;
	localparam int unsigned SEED_LSB  = COUNT_LSB + COUNT_W;
	localparam int unsigned LEN_LSB   = SEED_LSB + SEED_W;
	localparam int unsigned IN_BITS   = LEN_LSB + LEN_W;
	localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned HASH_W    = 64;

	// Operation being sequenced; also selects multiplier operands and writeback.
	typedef enum logic [1:0] {
		OP_INIT, // seed ^ (length * M)
		OP_MIXV, // hash ^= mix(word)
		OP_HM,   // hash *= M
		OP_FIN   // result = mix(hash)
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;      // capture the accepted input item
		logic       mul_ld;    // load multiplier operands for op
		logic       mul_run;   // advance the multiplier by one phase
		logic [1:0] mul_phase; // multiplier phase
		logic       wb;        // write the product back for op
		op_t        op;
	} dp_cmd_t;

	// Status from the datapath about the item on the input channel.
	typedef struct packed {
		logic first;
		logic last;
		logic has_data;
	} dp_sts_t;

endpackage

// ===== hdl/fh64_mul.sv =====
// Sequential 64 x 64 multiplier giving the low 64 bits of the product.
// Uses one 32 x 32 multiplier over four phases; depends on nothing.
module fh64_mul (
	input  logic        clk,
	input  logic        ld,
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic        run,
	input  logic [1:0]  phase,
	output logic [63:0] prod
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [63:0] acc_q;
	logic [31:0] m_x;
	logic [31:0] m_y;

	// Operand halves for the shared partial-product multiplier.
	always_comb begin
		unique case (phase)
			2'd0: begin
				m_x = a_q[31:0];
				m_y = b_q[31:0];
			end
			2'd1: begin
				m_x = a_q[31:0];
				m_y = b_q[63:32];
			end
			default: begin
				m_x = a_q[63:32];
				m_y = b_q[31:0];
			end
		endcase
	end

	// Low half product first, then the two cross terms shifted up by 32.
	always_ff @(posedge clk) begin
		if (ld) begin
			a_q <= a;
			b_q <= b;
		end
		if (run) begin
			p_q <= 64'(m_x) * 64'(m_y);
			unique case (phase)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= p_q;
				default: acc_q <= acc_q + {p_q[31:0], 32'd0};
			endcase
		end
	end

	assign prod = acc_q;

endmodule

// ===== hdl/fh64_dp.sv =====
// Datapath of the fasthash64 stream hash: input capture, running hash and result.
// Depends on fh64_pkg and instantiates fh64_mul.
module fh64_dp
	import fh64_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_TDATA_W-1:0] in_tdata,
	input  logic                  in_first,
	input  logic                  in_last,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	output logic [HASH_W-1:0]     hash_value
);

	logic [WORD_W-1:0]  word_in;
	logic [COUNT_W-1:0] count_in;
	logic [WORD_W-1:0]  word_masked;
	logic [WORD_W-1:0]  word_q;
	logic [SEED_W-1:0]  seed_q;
	logic [LEN_W-1:0]   len_q;
	logic [63:0]        hash_q;
	logic [63:0]        out_q;
	logic [63:0]        mul_a;
	logic [63:0]        mul_b;
	logic [63:0]        prod;

	function automatic logic [63:0] pre_mix(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT1);
	endfunction

	function automatic logic [63:0] post_mix(input logic [63:0] x);
		return x ^ (x >> MIX_SHIFT2);
	endfunction

	assign word_in  = in_tdata[WORD_LSB +: WORD_W];
	assign count_in = in_tdata[COUNT_LSB +: COUNT_W];

	// Bytes at or beyond the byte count are forced to zero; counts above eight keep all.
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			word_masked[i*8 +: 8] = (count_in > COUNT_W'(i)) ? word_in[i*8 +: 8] : 8'd0;
		end
	end

	assign sts.first    = in_first;
	assign sts.last     = in_last;
	assign sts.has_data = (count_in != '0);

	// Capture of the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= word_masked;
			seed_q <= in_tdata[SEED_LSB +: SEED_W];
			len_q  <= in_tdata[LEN_LSB +: LEN_W];
		end
	end

	// Multiplier operand selection per operation.
	always_comb begin
		unique case (cmd.op)
			OP_INIT: begin
				mul_a = 64'(len_q);
				mul_b = HASH_M;
			end
			OP_MIXV: begin
				mul_a = pre_mix(word_q);
				mul_b = MIX_MUL;
			end
			OP_HM: begin
				mul_a = hash_q;
				mul_b = HASH_M;
			end
			default: begin
				mul_a = pre_mix(hash_q);
				mul_b = MIX_MUL;
			end
		endcase
	end

	fh64_mul u_mul (
		.clk   (clk),
		.ld    (cmd.mul_ld),
		.a     (mul_a),
		.b     (mul_b),
		.run   (cmd.mul_run),
		.phase (cmd.mul_phase),
		.prod  (prod)
	);

	// Running hash is state that a word without a first marker continues from.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (cmd.wb) begin
			unique case (cmd.op)
				OP_INIT: hash_q <= seed_q ^ prod;
				OP_MIXV: hash_q <= hash_q ^ post_mix(prod);
				OP_HM:   hash_q <= prod;
				default: hash_q <= hash_q;
			endcase
		end
	end

	// Result register for the output channel.
	always_ff @(posedge clk) begin
		if (cmd.wb && (cmd.op == OP_FIN)) begin
			out_q <= post_mix(prod);
		end
	end

	assign hash_value = out_q;

endmodule

// ===== hdl/fh64_ctrl.sv =====
// Controller of the fasthash64 stream hash: sequences multiplies and handshakes.
// Depends on fh64_pkg and the assertion macro header.
`include "fasthash64_stream_hash_macros.svh"

module fh64_ctrl
	import fh64_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_WB
	} state_t;

	state_t     state_q;
	op_t        op_q;
	logic [1:0] phase_q;
	logic       data_q;
	logic       last_q;
	logic       out_valid_q;
	logic       in_accept;
	logic       out_free;
	logic       wb_go;
	logic       fin_wb;
	logic       mixv_wb;

	assign in_ready  = (state_q == S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	// The final writeback waits until the result register can take a new value.
	assign wb_go     = (state_q == S_WB) && ((op_q != OP_FIN) || out_free);
	assign fin_wb    = wb_go && (op_q == OP_FIN);
	assign mixv_wb   = wb_go && (op_q == OP_MIXV);
	assign out_valid = out_valid_q;

	// Commands to the datapath.
	always_comb begin
		cmd.load      = in_accept;
		cmd.mul_ld    = (state_q == S_LOAD);
		cmd.mul_run   = (state_q == S_MUL);
		cmd.mul_phase = phase_q;
		cmd.wb        = wb_go;
		cmd.op        = op_q;
	end

	// Sequencer state and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INIT;
			phase_q     <= '0;
			data_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A result stays valid until taken; the final writeback raises it again.
			out_valid_q <= (out_valid_q && !out_ready) || fin_wb;
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						data_q <= sts.has_data;
						last_q <= sts.last;
						priority if (sts.first) begin
							op_q    <= OP_INIT;
							state_q <= S_LOAD;
						end else if (sts.has_data) begin
							op_q    <= OP_MIXV;
							state_q <= S_LOAD;
						end else if (sts.last) begin
							op_q    <= OP_FIN;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LOAD: begin
					phase_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_go) begin
						unique case (op_q)
							OP_INIT: begin
								priority if (data_q) begin
									op_q    <= OP_MIXV;
									state_q <= S_LOAD;
								end else if (last_q) begin
									op_q    <= OP_FIN;
									state_q <= S_LOAD;
								end else begin
									state_q <= S_IDLE;
								end
							end
							OP_MIXV: begin
								op_q    <= OP_HM;
								state_q <= S_LOAD;
							end
							OP_HM: begin
								if (last_q) begin
									op_q    <= OP_FIN;
									state_q <= S_LOAD;
								end else begin
									state_q <= S_IDLE;
								end
							end
							OP_FIN: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result appears only through the final writeback.
	`FH64_ASSERT_IMP(a_out_from_fin, clk, arst_n, $rose(out_valid_q), $past(fin_wb))
	// A pending result is never overwritten before it is taken.
	`FH64_ASSERT_IMP(a_no_overwrite, clk, arst_n, fin_wb, !out_valid_q || out_ready)
	// Four multiplier phases always lead to writeback.
	`FH64_ASSERT_NXT(a_mul_len, clk, arst_n, (state_q == S_MUL) && (phase_q == 2'd3), state_q == S_WB)
	// The mixed word is always followed by the multiply by M.
	`FH64_ASSERT_NXT(a_mixv_then_hm, clk, arst_n, mixv_wb, (state_q == S_LOAD) && (op_q == OP_HM))

endmodule

// ===== hdl/fasthash64_stream_hash.sv =====
// Top level of the fasthash64 stream hash: joins the controller and the datapath.
// Depends on fh64_pkg, fh64_ctrl and fh64_dp.
//
// Channel  Direction  Payload
// s_axis   in         tdata: data_word, byte_count, seed, total_length; tuser: first; tlast: last
// m_axis   out        tdata: hash_value
//
// Each 64 x 64 multiply runs through operand load, four phases of the single
// 32 x 32 multiplier, and writeback. A word with data costs two multiplies,
// a first word adds one and a last word adds one. Input is taken only while the sequencer is idle;
// a result waiting on m_axis stalls only the next final writeback.
// Reset clears the running hash, the sequencer and the output valid flag.
module fasthash64_stream_hash
	import fh64_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// data_word [63:0], byte_count [67:64], seed [131:68], total_length [147:132], zero pad
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,
	// first [0]
	input  logic [0:0]            s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// hash_value [63:0]
	output logic [HASH_W-1:0]     m_axis_tdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	fh64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fh64_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_tdata   (s_axis_tdata),
		.in_first   (s_axis_tuser[0]),
		.in_last    (s_axis_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.hash_value (m_axis_tdata)
	);

endmodule
